@@ design/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold whenever reset is low
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/lmwfc_pkg.sv @@
// Package: codes, font and icon tables, microcode program of the frame composer
package lmwfc_pkg;

  localparam int FRAME_ROWS = 16;
  localparam int ROW_W      = $clog2(FRAME_ROWS);
  localparam int PIX_W      = 16;
  localparam int VALUE_W    = 8;
  localparam int FUNC_W     = 2;
  localparam int STEP_W     = 5;

  localparam logic [FUNC_W-1:0] FUNC_CUR   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FCST  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FRAME = 2'd2;

  localparam logic [VALUE_W-1:0] INVALID_VALUE = 8'd200;
  localparam logic [VALUE_W-1:0] FULL_PRECIP   = 8'd100;
  localparam logic [VALUE_W-1:0] MOON_FULL     = 8'd2;
  localparam logic [VALUE_W-1:0] MOON_ALMOST   = 8'd1;

  localparam logic [1:0] MOON_SEL_NONE   = 2'd0;
  localparam logic [1:0] MOON_SEL_FULL   = 2'd1;
  localparam logic [1:0] MOON_SEL_ALMOST = 2'd2;

  localparam int PRC_COL  = 9;
  localparam int MOON_COL = 10;

  // 3x5 digit font, top line in the upper three bits
  localparam logic [14:0] FONT [10] = '{
    15'b111_101_101_101_111, 15'b001_001_001_001_001, 15'b111_001_111_100_111,
    15'b111_001_011_001_111, 15'b101_101_111_001_001, 15'b111_100_111_001_111,
    15'b111_100_111_101_111, 15'b111_001_010_100_100, 15'b111_101_111_101_111,
    15'b111_101_111_001_111
  };

  localparam logic [6:0] ICON_BAR = 7'd127;
  localparam logic [6:0] ICON_RAIN [2] = '{7'd42, 7'd85};
  localparam logic [3:0] ICON_MOON_FULL   [4] = '{4'd6, 4'd15, 4'd15, 4'd6};
  localparam logic [3:0] ICON_MOON_ALMOST [4] = '{4'd6, 4'd9, 4'd9, 4'd6};

  typedef enum logic {SEQ_NEXT, SEQ_END} seq_t;

  typedef struct packed {
    logic             decode;
    logic             emit;
    logic [ROW_W-1:0] row;
    logic             bar;
    logic             max_en;
    logic [2:0]       max_line;
    logic             cur_en;
    logic [2:0]       cur_line;
    logic             prc_en;
    logic [2:0]       prc_line;
    logic             rain_en;
    logic             full_en;
    logic             icon_line;
    logic             moon_en;
    logic [1:0]       moon_line;
    seq_t             seq;
  } ucode_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] ones;
  } digits_t;

  function automatic logic [2:0] font_line(input logic [3:0] d, input logic [2:0] line);
    logic [14:0] f;
    logic [14:0] s;
    f = (d < 4'd10) ? FONT[d] : '0;
    s = f >> (3 * (4 - int'(line)));
    return (line < 3'd5) ? s[2:0] : 3'b000;
  endfunction

  // Value mod 100 split into digits: reciprocal multiply, exact for 0..99
  function automatic digits_t split_digits(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] r;
    logic [6:0]         m;
    logic [13:0]        prod;
    logic [3:0]         t;
    logic [6:0]         tx10;
    logic [6:0]         o;
    digits_t            d;
    if (v >= 8'd200) r = v - 8'd200;
    else if (v >= 8'd100) r = v - 8'd100;
    else r = v;
    m    = r[6:0];
    prod = 14'(m) * 14'd103;
    t    = prod[13:10];
    tx10 = {t, 3'b000} + {2'b00, t, 1'b0};
    o    = m - tx10;
    d.tens = t;
    d.ones = o[3:0];
    return d;
  endfunction

  // Two-digit field line: diagonal when invalid, else tens and ones glyphs
  function automatic logic [6:0] number_line(input logic inv, input digits_t d,
                                             input logic [2:0] line);
    logic [6:0] bits;
    if (inv) bits = 7'd1 << (line + 3'd1);
    else bits = {font_line(d.tens, line), 1'b0, font_line(d.ones, line)};
    return bits;
  endfunction

  // Program: step 0 decodes the stored values, steps 1..16 emit rows 0..15
  function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
    ucode_t     w;
    logic [STEP_W-1:0] r;
    w = '0;
    w.seq = SEQ_NEXT;
    r = step - 5'd1;
    if (step == 5'd0) begin
      w.decode = 1'b1;
    end else begin
      w.emit = 1'b1;
      w.row  = r[ROW_W-1:0];
    end
    unique case (step)
      5'd1:  w.bar = 1'b1;
      5'd2:  begin w.rain_en = 1'b1; w.icon_line = 1'b0; end
      5'd3:  begin
        w.max_en = 1'b1; w.max_line = 3'd0; w.rain_en = 1'b1; w.icon_line = 1'b1;
      end
      5'd4:  begin w.max_en = 1'b1; w.max_line = 3'd1; end
      5'd5:  begin
        w.max_en = 1'b1; w.max_line = 3'd2; w.prc_en = 1'b1; w.prc_line = 3'd0;
        w.full_en = 1'b1; w.icon_line = 1'b0;
      end
      5'd6:  begin
        w.max_en = 1'b1; w.max_line = 3'd3; w.prc_en = 1'b1; w.prc_line = 3'd1;
        w.full_en = 1'b1; w.icon_line = 1'b1;
      end
      5'd7:  begin
        w.max_en = 1'b1; w.max_line = 3'd4; w.prc_en = 1'b1; w.prc_line = 3'd2;
      end
      5'd8:  begin
        w.prc_en = 1'b1; w.prc_line = 3'd3; w.full_en = 1'b1; w.icon_line = 1'b0;
      end
      5'd9:  begin
        w.prc_en = 1'b1; w.prc_line = 3'd4; w.full_en = 1'b1; w.icon_line = 1'b1;
      end
      5'd11: begin w.cur_en = 1'b1; w.cur_line = 3'd0; end
      5'd12: begin
        w.cur_en = 1'b1; w.cur_line = 3'd1; w.moon_en = 1'b1; w.moon_line = 2'd0;
      end
      5'd13: begin
        w.cur_en = 1'b1; w.cur_line = 3'd2; w.moon_en = 1'b1; w.moon_line = 2'd1;
      end
      5'd14: begin
        w.cur_en = 1'b1; w.cur_line = 3'd3; w.moon_en = 1'b1; w.moon_line = 2'd2;
      end
      5'd15: begin
        w.cur_en = 1'b1; w.cur_line = 3'd4; w.moon_en = 1'b1; w.moon_line = 2'd3;
      end
      5'd16: w.seq = SEQ_END;
      default: ;
    endcase
    if (step > 5'd16) begin
      w.emit = 1'b0;
      w.seq  = SEQ_END;
    end
    return w;
  endfunction

endpackage

@@ design/lmwfc_in_if.sv @@
// Input channel: update and frame request items
interface lmwfc_in_if;
  import lmwfc_pkg::*;
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [VALUE_W-1:0] first_value;
  logic [VALUE_W-1:0] second_value;
  logic [VALUE_W-1:0] third_value;
  modport source (output valid, func, first_value, second_value, third_value,
                  input ready);
  modport sink (input valid, func, first_value, second_value, third_value,
                output ready);
endinterface

@@ design/lmwfc_out_if.sv @@
// Output channel: frame row items
interface lmwfc_out_if;
  import lmwfc_pkg::*;
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_index;
  logic [PIX_W-1:0] row_pixels;
  logic             last_row;
  modport source (output valid, row_index, row_pixels, last_row, input ready);
  modport sink (input valid, row_index, row_pixels, last_row, output ready);
endinterface

@@ design/led_matrix_weather_frame_composer_core.sv @@
// The input is refused while a frame is being composed. A frame request with redraw
// pending runs a 17-step microprogram: one decode step, then one row per cycle while
// the output does not stall. Output stalls hold the sequencer. Reset: all values 200,
// redraw pending, sequencer idle, output empty.
module led_matrix_weather_frame_composer_core (
  input  logic         clk,
  input  logic         rst,
  lmwfc_in_if.sink     req,
  lmwfc_out_if.source  rows
);
  import lmwfc_pkg::*;

  logic [VALUE_W-1:0] cur_temp, peak_temp, rain_pct, moon_phase;
  logic               redraw_pending;
  logic               busy;
  logic [STEP_W-1:0]  step;

  logic               ovalid;
  logic [ROW_W-1:0]   orow;
  logic [PIX_W-1:0]   opix;
  logic               olast;

  // decoded frame operands
  logic    max_inv, cur_inv, prc_mid, prc_full;
  digits_t max_d, cur_d, prc_d;
  logic [1:0] moon_sel;

  ucode_t     uw;
  logic       in_acc, advance;
  logic [PIX_W-1:0] pix;
  logic [6:0] icon;
  logic [3:0] moon_bits;

  assign uw      = ucode(step);
  assign in_acc  = req.valid && req.ready;
  assign advance = busy && (!uw.emit || !ovalid || rows.ready);

  assign req.ready       = !busy;
  assign rows.valid      = ovalid;
  assign rows.row_index  = orow;
  assign rows.row_pixels = opix;
  assign rows.last_row   = olast;

  always_comb begin
    icon = ICON_RAIN[uw.icon_line];
    unique case (moon_sel)
      MOON_SEL_FULL:   moon_bits = ICON_MOON_FULL[uw.moon_line];
      MOON_SEL_ALMOST: moon_bits = ICON_MOON_ALMOST[uw.moon_line];
      default:         moon_bits = 4'd0;
    endcase
    pix = '0;
    if (uw.bar) pix = pix | PIX_W'(ICON_BAR);
    if (uw.max_en) pix = pix | PIX_W'(number_line(max_inv, max_d, uw.max_line));
    if (uw.cur_en) pix = pix | PIX_W'(number_line(cur_inv, cur_d, uw.cur_line));
    if (uw.prc_en && prc_mid)
      pix = pix | (PIX_W'(number_line(1'b0, prc_d, uw.prc_line)) << PRC_COL);
    if ((uw.rain_en && prc_mid) || (uw.full_en && prc_full))
      pix = pix | (PIX_W'(icon) << PRC_COL);
    if (uw.moon_en) pix = pix | (PIX_W'(moon_bits) << MOON_COL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_temp       <= INVALID_VALUE;
      peak_temp      <= INVALID_VALUE;
      rain_pct       <= INVALID_VALUE;
      moon_phase     <= INVALID_VALUE;
      redraw_pending <= 1'b1;
      busy           <= 1'b0;
      step           <= '0;
      ovalid         <= 1'b0;
    end else begin
      if (ovalid && rows.ready && !(advance && uw.emit)) ovalid <= 1'b0;

      if (in_acc) begin
        unique case (req.func)
          FUNC_CUR: begin
            cur_temp <= req.first_value;
            if (req.first_value > peak_temp) peak_temp <= req.first_value;
            if (req.first_value != cur_temp) redraw_pending <= 1'b1;
          end
          FUNC_FCST: begin
            peak_temp  <= req.first_value;
            rain_pct   <= req.second_value;
            moon_phase <= req.third_value;
            if (req.first_value != peak_temp || req.second_value != rain_pct ||
                req.third_value != moon_phase)
              redraw_pending <= 1'b1;
          end
          FUNC_FRAME: begin
            if (redraw_pending) begin
              redraw_pending <= 1'b0;
              busy           <= 1'b1;
              step           <= '0;
            end
          end
          default: ;
        endcase
      end

      if (advance) begin
        if (uw.decode) begin
          max_inv  <= (peak_temp == INVALID_VALUE);
          cur_inv  <= (cur_temp == INVALID_VALUE);
          max_d    <= split_digits(peak_temp);
          cur_d    <= split_digits(cur_temp);
          prc_d    <= split_digits(rain_pct);
          prc_mid  <= (rain_pct != '0) && (rain_pct < FULL_PRECIP);
          prc_full <= (rain_pct == FULL_PRECIP);
          if (moon_phase == MOON_FULL) moon_sel <= MOON_SEL_FULL;
          else if (moon_phase == MOON_ALMOST) moon_sel <= MOON_SEL_ALMOST;
          else moon_sel <= MOON_SEL_NONE;
        end
        if (uw.emit) begin
          ovalid <= 1'b1;
          orow   <= uw.row;
          opix   <= pix;
          olast  <= (uw.seq == SEQ_END);
        end
        unique case (uw.seq)
          SEQ_END:  busy <= 1'b0;
          SEQ_NEXT: step <= step + 5'd1;
          default:  busy <= 1'b0;
        endcase
      end
    end
  end

endmodule

@@ design/lmwfc_chk.sv @@
// Port checker for the frame composer, bound to the core module
`include "assert_macros.svh"

module lmwfc_chk (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [lmwfc_pkg::ROW_W-1:0] row_index,
  input logic [lmwfc_pkg::PIX_W-1:0] row_pixels,
  input logic                    last_row
);
  import lmwfc_pkg::*;

  `ASSERT_IMPLIES(a_last_flag, out_valid, last_row == (row_index == 4'd15), "last_row flag disagrees with row index")
  `ASSERT_NEXT(a_row_order, out_valid && out_ready && !last_row, out_valid && row_index == $past(row_index) + 4'd1, "frame rows not emitted back to back in order")
  `ASSERT_IMPLIES(a_frame_blocks, out_valid && !last_row, !in_ready, "input taken while a frame is being emitted")
  `ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(row_index) && $stable(row_pixels), "stalled row item changed")

endmodule

bind led_matrix_weather_frame_composer_core lmwfc_chk u_lmwfc_chk (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (req.ready),
  .out_valid  (rows.valid),
  .out_ready  (rows.ready),
  .row_index  (rows.row_index),
  .row_pixels (rows.row_pixels),
  .last_row   (rows.last_row)
);
